>>> rtl/core/double_ended_queue_defines.svh
// Assertion macros used by the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define DEQ_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define DEQ_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define DEQ_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/deq_pkg.sv
// Shared types, codes and constants of the double-ended queue.
package deq_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 16;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [DATA_W-1:0]   word_t;

    localparam op_t OP_PUSH_FRONT = 3'd0;
    localparam op_t OP_PUSH_REAR  = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_REAR   = 3'd3;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    // Movement command for a row or for a single cell. shift_up takes the
    // word of the lower neighbour, shift_down that of the upper neighbour,
    // and load takes the pushed word.
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load;
    } move_t;

endpackage

>>> rtl/core/deq_cell.sv
// One storage cell of a deque row: holds a word, shifted in from a neighbour.
module deq_cell
    import deq_pkg::*;
(
    input  logic  clk,
    input  move_t move,
    input  word_t word,
    input  word_t lower_data,
    input  word_t upper_data,
    output word_t data,
    output word_t data_next
);

    word_t data_reg;

    always_comb
    begin
        if (move.shift_up)
        begin
            data_next = lower_data;
        end
        else if (move.shift_down)
        begin
            data_next = upper_data;
        end
        else if (move.load)
        begin
            data_next = word;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> rtl/core/deq_row.sv
// A row of deque cells with one end fixed at cell zero.
module deq_row
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  move_t            move,
    input  logic [CNT_W-1:0] count,
    input  word_t            word,
    output word_t            head,
    output word_t            head_next
);

    word_t cell_data [DEPTH];
    word_t cell_next [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        move_t cell_move;
        word_t lower_data;
        word_t upper_data;

        // A load lands only in the first free cell behind the occupied run.
        assign cell_move.shift_up   = move.shift_up;
        assign cell_move.shift_down = move.shift_down;
        assign cell_move.load       = move.load && (count == CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign lower_data = word;
        end
        else
        begin : g_inner
            assign lower_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper_data = '0;
        end
        else
        begin : g_below
            assign upper_data = cell_data[i+1];
        end

        deq_cell u_cell (
            .clk        (clk),
            .move       (cell_move),
            .word       (word),
            .lower_data (lower_data),
            .upper_data (upper_data),
            .data       (cell_data[i]),
            .data_next  (cell_next[i])
        );
    end

    assign head      = cell_data[0];
    assign head_next = cell_next[0];

endmodule

>>> rtl/core/double_ended_queue.sv
// Top level of the bounded double-ended queue of 32-bit words.
//
// Input channel s_axis: tuser carries the operation (push front, push rear,
// pop front, pop rear, anything else is a no-op) and tdata the word to push.
// Output channel m_axis: one transaction per input transaction, in order.
// tuser carries the status and tdata the popped word, the front and rear
// words after the step (all ones when empty), the empty flag and the count.
//
// The contents are held twice, in two rows of DEPTH cells: one row keeps
// the front word in its first cell, the other keeps the rear word there.
// A push or pop at one end shifts that row by one cell and writes or drops
// the far end of the other row. The result is registered and appears in the
// cycle after the input transaction is accepted, and one item is
// accepted every cycle while the result register is free or being emptied.
// If the receiver stalls, the result is held and s_axis_tready drops until
// it is taken. Reset empties the queue and the result register; the cell
// contents need no clearing, as only occupied cells are ever read.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int CNT_W   = $clog2(DEPTH + 1),
    localparam int OUT_W   = 3 * DATA_W + 1 + CNT_W,
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [DATA_W-1:0]  s_axis_tdata,   // push_value
    input  logic [OP_W-1:0]    s_axis_tuser,   // op
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // popped_value, front_value, rear_value, is_empty, fill_count, zero pad
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [STATUS_W-1:0] m_axis_tuser   // status
);

    logic             fire;
    op_t              op;
    word_t            word;
    logic             full;
    logic             empty;
    move_t            front_move;
    move_t            rear_move;
    status_t          status;
    word_t            popped;
    word_t            front_head;
    word_t            front_head_next;
    word_t            rear_head;
    word_t            rear_head_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    word_t            popped_reg;
    status_t          status_reg;
    word_t            front_reg;
    word_t            rear_reg;
    logic             empty_reg;
    logic [CNT_W-1:0] fill_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign op            = s_axis_tuser;
    assign word          = s_axis_tdata;
    assign full          = (count_reg == CNT_W'(DEPTH));
    assign empty         = (count_reg == '0);

    always_comb
    begin
        front_move = '0;
        rear_move  = '0;
        status     = STATUS_OK;
        popped     = '0;
        count_next = count_reg;
        unique case (op)
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = STATUS_FULL;
                end
                else
                begin
                    front_move.shift_up = fire;
                    rear_move.load      = fire;
                    count_next          = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_REAR:
            begin
                if (full)
                begin
                    status = STATUS_FULL;
                end
                else
                begin
                    rear_move.shift_up = fire;
                    front_move.load    = fire;
                    count_next         = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status = STATUS_EMPTY;
                end
                else
                begin
                    popped                = front_head;
                    front_move.shift_down = fire;
                    count_next            = count_reg - CNT_W'(1);
                end
            end
            OP_POP_REAR:
            begin
                if (empty)
                begin
                    status = STATUS_EMPTY;
                end
                else
                begin
                    popped               = rear_head;
                    rear_move.shift_down = fire;
                    count_next           = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status = STATUS_OK;
            end
        endcase
    end

    deq_row #(
        .DEPTH (DEPTH)
    ) u_front_row (
        .clk       (clk),
        .move      (front_move),
        .count     (count_reg),
        .word      (word),
        .head      (front_head),
        .head_next (front_head_next)
    );

    deq_row #(
        .DEPTH (DEPTH)
    ) u_rear_row (
        .clk       (clk),
        .move      (rear_move),
        .count     (count_reg),
        .word      (word),
        .head      (rear_head),
        .head_next (rear_head_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            popped_reg <= popped;
            status_reg <= status;
            front_reg  <= (count_next == '0) ? '1 : front_head_next;
            rear_reg   <= (count_next == '0) ? '1 : rear_head_next;
            empty_reg  <= (count_next == '0);
            fill_reg   <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = TDATA_W'({fill_reg, empty_reg, rear_reg, front_reg, popped_reg});

endmodule

>>> rtl/core/deq_checker.sv
// Port-level checks of the double-ended queue and their binding to the top level.
`include "double_ended_queue_defines.svh"

module deq_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int CNT_W   = $clog2(DEPTH + 1),
    localparam int OUT_W   = 3 * DATA_W + 1 + CNT_W,
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [TDATA_W-1:0]  m_axis_tdata,
    input logic [STATUS_W-1:0] m_axis_tuser
);

    word_t            popped;
    word_t            front;
    word_t            rear;
    logic             empty;
    logic [CNT_W-1:0] fill;

    assign popped = m_axis_tdata[DATA_W-1:0];
    assign front  = m_axis_tdata[2*DATA_W-1:DATA_W];
    assign rear   = m_axis_tdata[3*DATA_W-1:2*DATA_W];
    assign empty  = m_axis_tdata[3*DATA_W];
    assign fill   = m_axis_tdata[3*DATA_W+1 +: CNT_W];

    // A stalled result must not change until it is taken.
    `DEQ_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // The empty flag, the count and the end words must agree.
    `DEQ_ASSERT_IMP(a_empty_flag, m_axis_tvalid, empty == (fill == '0), "empty flag disagrees with count")
    `DEQ_ASSERT_IMP(a_empty_ends, m_axis_tvalid && empty, (front == '1) && (rear == '1), "empty queue shows end words")

    // A rejected operation never reports a popped word.
    `DEQ_ASSERT_IMP(a_reject_zero, m_axis_tvalid && (m_axis_tuser != STATUS_OK), popped == '0, "rejected operation popped a word")

    `DEQ_ASSERT_NOW(a_fill_bound, !m_axis_tvalid || (fill <= CNT_W'(DEPTH)), "count exceeds capacity")

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

>>> tb/double_ended_queue_tb.sv
// Self-checking testbench for the double-ended queue: directed rows, then biased random traffic.
module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int RING_DEPTH      = DEPTH_DEFAULT;
    localparam int COUNT_W         = $clog2(RING_DEPTH + 1);
    localparam int RESULT_W        = 3 * DATA_W + 1 + COUNT_W;
    localparam int RESULT_PADDED_W = ((RESULT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_ITEMS    = 700;
    localparam int PHASE_COUNT     = 4;
    localparam int DIRECTED_ROWS   = 19;

    localparam op_t   OP_NOP     = 3'd4;
    localparam op_t   OP_SPARE_A = 3'd5;
    localparam op_t   OP_SPARE_B = 3'd6;
    localparam op_t   OP_SPARE_C = 3'd7;
    localparam word_t EMPTY_WORD = 32'hFFFF_FFFF;

    typedef struct packed {
        word_t              popped_value;
        status_t            status;
        word_t              front_value;
        word_t              rear_value;
        logic               is_empty;
        logic [COUNT_W-1:0] fill_count;
    } deque_result_t;

    typedef struct {
        op_t           op;
        word_t         value;
        int            reps;
        bit            typed;
        deque_result_t want;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [DATA_W-1:0]          s_axis_tdata;   // push_value
    logic [OP_W-1:0]            s_axis_tuser;   // op
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    // popped_value, front_value, rear_value, is_empty, fill_count, zero pad
    logic [RESULT_PADDED_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]        m_axis_tuser;   // status

    // Shadow copy of the ring, advanced once per accepted input transaction.
    word_t ring_slots [RING_DEPTH];
    int    ring_head;
    int    ring_count;

    deque_result_t expected_results [$];
    int            error_count;
    int            cycle_count;
    int            sender_idle_pct;
    int            receiver_stall_pct;
    int            hold_off_requests;
    int            hold_off_served;
    int            hold_off_left;

    // Rows with typed set carry a result that is plain from the operation alone.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_POP_FRONT,  32'h0000_0000, 1, 1'b1,
          '{32'h0, STATUS_EMPTY, EMPTY_WORD, EMPTY_WORD, 1'b1, 5'd0}},
        '{OP_POP_REAR,   32'h0000_0000, 1, 1'b1,
          '{32'h0, STATUS_EMPTY, EMPTY_WORD, EMPTY_WORD, 1'b1, 5'd0}},
        '{OP_NOP,        32'hDEAD_BEEF, 1, 1'b1,
          '{32'h0, STATUS_OK, EMPTY_WORD, EMPTY_WORD, 1'b1, 5'd0}},
        '{OP_PUSH_REAR,  32'h7FFF_FFFF, 1, 1'b1,
          '{32'h0, STATUS_OK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 5'd1}},
        '{OP_PUSH_FRONT, 32'h8000_0000, 1, 1'b1,
          '{32'h0, STATUS_OK, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 5'd2}},
        '{OP_SPARE_A,    32'hFFFF_FFFF, 1, 1'b1,
          '{32'h0, STATUS_OK, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 5'd2}},
        '{OP_SPARE_B,    32'h0000_0000, 1, 1'b1,
          '{32'h0, STATUS_OK, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 5'd2}},
        '{OP_SPARE_C,    32'h5555_5555, 1, 1'b1,
          '{32'h0, STATUS_OK, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 5'd2}},
        '{OP_POP_REAR,   32'h0000_0000, 1, 1'b1,
          '{32'h7FFF_FFFF, STATUS_OK, 32'h8000_0000, 32'h8000_0000, 1'b0, 5'd1}},
        '{OP_POP_FRONT,  32'h0000_0000, 1, 1'b1,
          '{32'h8000_0000, STATUS_OK, EMPTY_WORD, EMPTY_WORD, 1'b1, 5'd0}},
        '{OP_PUSH_FRONT, 32'h0000_0000, 1, 1'b1,
          '{32'h0, STATUS_OK, 32'h0, 32'h0, 1'b0, 5'd1}},
        '{OP_POP_REAR,   32'h0000_0000, 1, 1'b1,
          '{32'h0, STATUS_OK, EMPTY_WORD, EMPTY_WORD, 1'b1, 5'd0}},
        '{OP_PUSH_FRONT, 32'h1000_0000, 9, 1'b0, '0},
        '{OP_PUSH_REAR,  32'hAAAA_0000, 7, 1'b0, '0},
        '{OP_PUSH_REAR,  32'h1234_5678, 1, 1'b0, '0},
        '{OP_PUSH_FRONT, 32'h8765_4321, 1, 1'b0, '0},
        '{OP_POP_REAR,   32'h0000_0000, 8, 1'b0, '0},
        '{OP_POP_FRONT,  32'h0000_0000, 8, 1'b0, '0},
        '{OP_POP_FRONT,  32'h0000_0000, 1, 1'b1,
          '{32'h0, STATUS_EMPTY, EMPTY_WORD, EMPTY_WORD, 1'b1, 5'd0}}
    };

    double_ended_queue #(.DEPTH(RING_DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic deque_result_t deque_step(op_t op, word_t value);
        deque_result_t res;
        res.popped_value = '0;
        res.status       = STATUS_OK;
        res.front_value  = EMPTY_WORD;
        res.rear_value   = EMPTY_WORD;
        case (op) inside
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (ring_count >= RING_DEPTH)
                begin
                    res.status = STATUS_FULL;
                end
                else if (op == OP_PUSH_FRONT)
                begin
                    ring_head = (ring_head + RING_DEPTH - 1) % RING_DEPTH;
                    ring_slots[ring_head] = value;
                    ring_count++;
                end
                else
                begin
                    ring_slots[(ring_head + ring_count) % RING_DEPTH] = value;
                    ring_count++;
                end
            end
            OP_POP_FRONT, OP_POP_REAR:
            begin
                if (ring_count == 0)
                begin
                    res.status = STATUS_EMPTY;
                end
                else if (op == OP_POP_FRONT)
                begin
                    res.popped_value = ring_slots[ring_head];
                    ring_head = (ring_head + 1) % RING_DEPTH;
                    ring_count--;
                end
                else
                begin
                    res.popped_value = ring_slots[(ring_head + ring_count - 1) % RING_DEPTH];
                    ring_count--;
                end
            end
            default:
            begin
            end
        endcase
        if (ring_count != 0)
        begin
            res.front_value = ring_slots[ring_head];
            res.rear_value  = ring_slots[(ring_head + ring_count - 1) % RING_DEPTH];
        end
        res.is_empty   = (ring_count == 0);
        res.fill_count = COUNT_W'(ring_count);
        return res;
    endfunction

    // Offers one transaction and returns at the edge that accepts it; tvalid is
    // left high so that a following item can go out back to back.
    task automatic send_item(op_t op, word_t value, bit typed, deque_result_t want);
        deque_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predicted = deque_step(op, value);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic check_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            error_count++;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (hold_off_requests != hold_off_served)
        begin
            hold_off_served++;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, actual %h %h",
                         $time, m_axis_tuser, m_axis_tdata);
                error_count++;
            end
            else
            begin
                deque_result_t want;
                want = expected_results.pop_front();
                check_field("popped_value", want.popped_value, m_axis_tdata[31:0]);
                check_field("front_value", want.front_value, m_axis_tdata[63:32]);
                check_field("rear_value", want.rear_value, m_axis_tdata[95:64]);
                check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(m_axis_tdata[96]));
                check_field("fill_count", DATA_W'(want.fill_count),
                            DATA_W'(m_axis_tdata[97 +: COUNT_W]));
                check_field("status", DATA_W'(want.status), DATA_W'(m_axis_tuser));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int    fill_target;
        int    pick;
        op_t   op;
        word_t value;
        error_count        = 0;
        cycle_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_requests  = 0;
        hold_off_served    = 0;
        hold_off_left      = 0;
        ring_head          = 0;
        ring_count         = 0;
        fill_target        = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_NOP;
        m_axis_tready <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            for (int k = 0; k < directed_rows[i].reps; k++)
            begin
                send_item(directed_rows[i].op, directed_rows[i].value + word_t'(k),
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end
        drain_results();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
                default: begin sender_idle_pct = 8;  receiver_stall_pct = 8;  end
            endcase
            // Back-to-back traffic against a stopped receiver fills the result path.
            if (phase == 0)
            begin
                hold_off_requests++;
            end
            for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++)
            begin
                // The fill level drifts towards a target that favours empty and full.
                if (n % 40 == 0)
                begin
                    pick = $urandom_range(3);
                    fill_target = (pick == 0) ? 0 : (pick == 1) ? RING_DEPTH + 2
                                : $urandom_range(RING_DEPTH);
                end
                pick = $urandom_range(99);
                if (pick < 8)
                begin
                    op = op_t'($urandom_range(OP_SPARE_C, OP_NOP));
                end
                else if ((ring_count < fill_target) == ($urandom_range(99) < 80))
                begin
                    op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
                end
                else
                begin
                    op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
                end
                case ($urandom_range(19))
                    0:       value = 32'h0000_0000;
                    1:       value = 32'hFFFF_FFFF;
                    2:       value = 32'h8000_0000;
                    3:       value = 32'h7FFF_FFFF;
                    default: value = $urandom;
                endcase
                send_item(op, value, 1'b0, '0);
            end
            drain_results();
        end

        repeat (4) @(posedge clk);
        if (error_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
